// ===== rtl/core/bbr_pkg.sv =====
// Shared constants, request/response types and codes for the bit reader.
// No dependencies; imported by every module of the block.
package bbr_pkg;

  localparam int WINDOW_BITS   = 128;
  localparam int MAX_READ_BITS = 64;
  localparam int FILL_W        = $clog2(WINDOW_BITS + 1);
  localparam int RD_W          = $clog2(MAX_READ_BITS + 1);
  localparam int CNT_W         = 16;
  localparam int POS_W         = 48;
  localparam int VALUE_W       = 64;
  localparam int BYTE_W        = 8;

  typedef enum logic [1:0] {
    REQ_FEED = 2'd0,
    REQ_READ = 2'd1,
    REQ_PEEK = 2'd2,
    REQ_SKIP = 2'd3
  } req_type_t;

  typedef enum logic [1:0] {
    ST_OK     = 2'd0,
    ST_SHORT  = 2'd1,
    ST_FULL   = 2'd2,
    ST_BADLEN = 2'd3
  } status_t;

  typedef struct packed {
    req_type_t          req_type;
    logic [BYTE_W-1:0]  data_byte;
    logic [CNT_W-1:0]   bit_count;
  } req_t;

  typedef struct packed {
    logic [VALUE_W-1:0] bits_value;
    status_t            status;
    logic [POS_W-1:0]   bit_position;
  } rsp_t;

  // handshake control between the pipeline stages
  typedef struct packed {
    logic fire;     // request register holds a beat and it executes now
    logic advance;  // result register can take a new beat this cycle
  } pipe_ctl_t;

endpackage

// ===== rtl/core/bbr_in_stage.sv =====
// Request register of the bit reader: captures one input beat per cycle unless stalled.
// Depends on bbr_pkg.
module bbr_in_stage
  import bbr_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_stall,
  input  req_t      in_req,
  input  pipe_ctl_t ctl,
  output logic      req_valid,
  output req_t      req
);

  logic valid_r, valid_nxt;
  req_t req_r;

  // hold only when a beat is waiting and the result side cannot move
  assign in_stall = valid_r && !ctl.advance;

  always_comb begin
    valid_nxt = valid_r;
    if (!in_stall) begin
      valid_nxt = in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!in_stall && in_valid) begin
      req_r <= in_req;
    end
  end

  assign req_valid = valid_r;
  assign req       = req_r;

endmodule

// ===== rtl/core/bbr_engine.sv =====
// Bit window state and single-pass datapath: append, extract, drop.
// Depends on bbr_pkg.
module bbr_engine
  import bbr_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  pipe_ctl_t ctl,
  input  req_t      req,
  output rsp_t      rsp
);

  logic [WINDOW_BITS-1:0] win_r, win_nxt;
  logic [FILL_W-1:0]      fill_r, fill_nxt;
  logic [CNT_W-1:0]       pend_r, pend_nxt;
  logic [POS_W-1:0]       cons_r, cons_nxt;

  logic [CNT_W-1:0]         n;
  logic [CNT_W-1:0]         fill_ext;
  logic                     short_buf;
  logic                     bad_len;
  logic [RD_W-1:0]          rd_len;
  logic [MAX_READ_BITS-1:0] win_top;
  logic [MAX_READ_BITS-1:0] ext;
  logic [CNT_W-1:0]         rest;
  logic [CNT_W:0]           skip_sum;
  logic [FILL_W-1:0]        drop_amt;
  logic [WINDOW_BITS-1:0]   win_drop;
  logic [WINDOW_BITS-1:0]   byte_pad;
  logic [WINDOW_BITS-1:0]   win_app;
  logic [WINDOW_BITS-1:0]   win_feed;
  logic [FILL_W-1:0]        cons_inc;
  logic [VALUE_W-1:0]       value;
  status_t                  status;

  assign n         = req.bit_count;
  assign fill_ext  = CNT_W'(fill_r);
  assign short_buf = n > fill_ext;
  assign bad_len   = (n == '0) || (n > CNT_W'(MAX_READ_BITS));

  // oldest bits sit at the top; right-align the first rd_len of them
  assign rd_len  = n[RD_W-1:0];
  assign win_top = win_r[WINDOW_BITS-1 -: MAX_READ_BITS];
  assign ext     = win_top >> (RD_W'(MAX_READ_BITS) - rd_len);

  assign rest     = n - fill_ext;
  assign skip_sum = {1'b0, pend_r} + {1'b0, rest};

  // one shared drop shifter: read length, skip length, or whole window
  assign drop_amt = (req.req_type == REQ_SKIP && short_buf) ? fill_r : n[FILL_W-1:0];
  assign win_drop = win_r << drop_amt;

  // bits below fill are always zero, so append is an OR
  assign byte_pad = {req.data_byte, {(WINDOW_BITS-BYTE_W){1'b0}}};
  assign win_app  = win_r | (byte_pad >> fill_r);
  assign win_feed = win_app << pend_r[2:0];

  always_comb begin
    win_nxt  = win_r;
    fill_nxt = fill_r;
    pend_nxt = pend_r;
    cons_inc = '0;
    value    = '0;
    status   = ST_OK;
    case (req.req_type)
      REQ_FEED: begin
        if (pend_r >= CNT_W'(BYTE_W)) begin
          pend_nxt = pend_r - CNT_W'(BYTE_W);
          cons_inc = FILL_W'(BYTE_W);
        end else if (fill_r > FILL_W'(WINDOW_BITS - BYTE_W)) begin
          status = ST_FULL;
        end else begin
          // leftover skip below a byte comes off the freshly fed bits
          win_nxt  = win_feed;
          fill_nxt = fill_r + FILL_W'(BYTE_W) - FILL_W'(pend_r[2:0]);
          pend_nxt = '0;
          cons_inc = FILL_W'(pend_r[2:0]);
        end
      end
      REQ_READ, REQ_PEEK: begin
        if (bad_len) begin
          status = ST_BADLEN;
        end else if (short_buf) begin
          status = ST_SHORT;
        end else begin
          value = VALUE_W'(ext);
          if (req.req_type == REQ_READ) begin
            win_nxt  = win_drop;
            fill_nxt = fill_r - drop_amt;
            cons_inc = drop_amt;
          end
        end
      end
      REQ_SKIP: begin
        if (!short_buf) begin
          win_nxt  = win_drop;
          fill_nxt = fill_r - drop_amt;
          cons_inc = drop_amt;
        end else if (skip_sum[CNT_W]) begin
          status = ST_BADLEN;
        end else begin
          win_nxt  = '0;
          fill_nxt = '0;
          cons_inc = fill_r;
          pend_nxt = skip_sum[CNT_W-1:0];
        end
      end
      default: begin
        status = ST_OK;
      end
    endcase
    cons_nxt = cons_r + POS_W'(cons_inc);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      win_r  <= '0;
      fill_r <= '0;
      pend_r <= '0;
      cons_r <= '0;
    end else if (ctl.fire) begin
      win_r  <= win_nxt;
      fill_r <= fill_nxt;
      pend_r <= pend_nxt;
      cons_r <= cons_nxt;
    end
  end

  assign rsp.bits_value   = value;
  assign rsp.status       = status;
  assign rsp.bit_position = cons_nxt;

endmodule

// ===== rtl/core/bbr_out_stage.sv =====
// Result register of the bit reader with valid/stall hold.
// Depends on bbr_pkg.
module bbr_out_stage
  import bbr_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      req_valid,
  input  rsp_t      rsp,
  output pipe_ctl_t ctl,
  output logic      out_valid,
  input  logic      out_stall,
  output rsp_t      out_rsp
);

  logic valid_r, valid_nxt;
  rsp_t rsp_r;

  assign ctl.advance = !valid_r || !out_stall;
  assign ctl.fire    = req_valid && ctl.advance;

  always_comb begin
    valid_nxt = valid_r;
    if (ctl.advance) begin
      valid_nxt = req_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.fire) begin
      rsp_r <= rsp;
    end
  end

  assign out_valid = valid_r;
  assign out_rsp   = rsp_r;

endmodule

// ===== rtl/core/bitstream_bit_reader_top.sv =====
// Top level of the MSB-first bitstream reader.
// Depends on bbr_pkg, bbr_in_stage, bbr_engine, bbr_out_stage.
//
// Usage:
//   Input channel (in_valid / in_stall): one request beat carries
//   in_req_type (feed, read, peek, skip), in_data_byte (fed byte) and
//   in_bit_count (read/peek length 1..64, or skip length).
//   Result channel (out_valid / out_stall): one beat per request with
//   out_bits_value (right-aligned bits, zero unless a successful read or
//   peek), out_status (ok, too few bits, window full, bad length) and
//   out_bit_position (bits consumed so far, modulo 2^48).
//   Path: input beat to request register, then window update and result
//   register in the same cycle. Throughput: one request per cycle unless
//   stalled; the whole request is one pass through the append /
//   extract / drop shifters of the 128-bit window.
//   Stall: while the result register is full and out_stall is high, the
//   request register holds and in_stall rises only if it holds a beat.
//   Reset (rst_n low, synchronous): window, fill count, pending skip and
//   position clear; both valid flags drop.
module bitstream_bit_reader_top
  import bbr_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [1:0]         in_req_type,
  input  logic [BYTE_W-1:0]  in_data_byte,
  input  logic [CNT_W-1:0]   in_bit_count,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [VALUE_W-1:0] out_bits_value,
  output logic [1:0]         out_status,
  output logic [POS_W-1:0]   out_bit_position
);

  req_t      in_req;
  req_t      req;
  logic      req_valid;
  rsp_t      rsp;
  rsp_t      out_rsp;
  pipe_ctl_t ctl;

  assign in_req.req_type  = req_type_t'(in_req_type);
  assign in_req.data_byte = in_data_byte;
  assign in_req.bit_count = in_bit_count;

  bbr_in_stage u_in (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_req    (in_req),
    .ctl       (ctl),
    .req_valid (req_valid),
    .req       (req)
  );

  // window state changes only when a request actually executes
  bbr_engine u_eng (
    .clk   (clk),
    .rst_n (rst_n),
    .ctl   (ctl),
    .req   (req),
    .rsp   (rsp)
  );

  bbr_out_stage u_out (
    .clk       (clk),
    .rst_n     (rst_n),
    .req_valid (req_valid),
    .rsp       (rsp),
    .ctl       (ctl),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_rsp   (out_rsp)
  );

  assign out_bits_value   = out_rsp.bits_value;
  assign out_status       = 2'(out_rsp.status);
  assign out_bit_position = out_rsp.bit_position;

endmodule

// ===== rtl/core/bbr_checker.sv =====
// Port-level checks for the bit reader, bound to the top level.
// Depends on bbr_pkg and bitstream_bit_reader_top.
module bbr_checker
  import bbr_pkg::*;
(
  input logic               clk,
  input logic               rst_n,
  input logic               in_stall,
  input logic               out_valid,
  input logic               out_stall,
  input logic [VALUE_W-1:0] out_bits_value,
  input logic [1:0]         out_status,
  input logic [POS_W-1:0]   out_bit_position
);

  // a stalled result beat holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_bits_value)
      && $stable(out_status) && $stable(out_bit_position))
    else $error("result beat changed under stall");

  // any failed request returns no bits
  a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_status != 2'(ST_OK)) |-> out_bits_value == '0)
    else $error("nonzero value with failing status");

  // input backpressure only comes from a blocked result beat
  a_stall_src: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> out_valid && out_stall)
    else $error("input stalled without result backpressure");

  // reset empties the result register
  a_rst_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid && !in_stall)
    else $error("valid result after reset");

endmodule

bind bitstream_bit_reader_top bbr_checker u_bbr_chk (
  .clk              (clk),
  .rst_n            (rst_n),
  .in_stall         (in_stall),
  .out_valid        (out_valid),
  .out_stall        (out_stall),
  .out_bits_value   (out_bits_value),
  .out_status       (out_status),
  .out_bit_position (out_bit_position)
);
